// File: src/lru_block_cache_lookup_unit_macros.svh
// Assertion helpers for the block cache lookup unit
`ifndef LRU_BLOCK_CACHE_LOOKUP_UNIT_MACROS_SVH
`define LRU_BLOCK_CACHE_LOOKUP_UNIT_MACROS_SVH
// implication checked on every clock, off during reset
`define LBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: src/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared constants and types of the block cache lookup unit.
// ----------------------------------------------------------------------------
package lbc_pkg;
    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int POS_W      = 40;
    localparam int CNT_W      = 32;
    localparam int AGE_W      = 64;
    localparam int MAX_BLOCKS = 64;

    typedef enum logic [1:0] {
        CFG_BLOCK_UNITS  = 2'd0,
        CFG_FILE_LENGTH  = 2'd1,
        CFG_ACTIVE_SLOTS = 2'd2
    } t_cfg_idx;

    // result of one slot scan
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_scan_res;
endpackage

// File: src/lbc_tag_scan.sv
// ----------------------------------------------------------------------------
// lbc_tag_scan
// Tag store with a one-slot-per-cycle compare unit: hit, free and oldest.
// ----------------------------------------------------------------------------
module lbc_tag_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lbc_pkg::POS_W-1:0] i_pos,
    input  logic [6:0]                i_nslots,
    input  logic                      i_touch,
    input  logic [lbc_pkg::SLOT_W-1:0] i_touch_slot,
    input  logic                      i_touch_fill,
    input  logic [lbc_pkg::AGE_W-1:0] i_age,
    output logic                      o_done,
    output lbc_pkg::t_scan_res        o_res
);
    import lbc_pkg::*;
    `include "lru_block_cache_lookup_unit_macros.svh"

    logic [POS_W-1:0]  r_tag   [NUM_SLOTS];
    logic [AGE_W-1:0]  r_age   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;
    logic              r_busy;
    logic [6:0]        r_idx;
    logic              r_hit, r_free;
    logic [SLOT_W-1:0] r_hit_slot, r_free_slot, r_old_slot;
    logic [AGE_W-1:0]  r_old_age;
    logic [SLOT_W-1:0] w_i;

    assign w_i    = r_idx[SLOT_W-1:0];
    assign o_done = r_busy && (r_idx == i_nslots);
    always_comb begin
        o_res.hit  = r_hit;
        o_res.slot = r_hit ? r_hit_slot : (r_free ? r_free_slot : r_old_slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_busy  <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
                r_old_slot <= '0;
            end else if (r_busy && r_idx != i_nslots) begin
                if (!r_valid[w_i]) begin
                    if (!r_free) begin
                        r_free      <= 1'b1;
                        r_free_slot <= w_i;
                    end
                end else begin
                    if (!r_hit && r_tag[w_i] == i_pos) begin
                        r_hit      <= 1'b1;
                        r_hit_slot <= w_i;
                    end
                    if (r_idx == 7'd0 || r_age[w_i] < r_old_age) begin
                        r_old_age  <= r_age[w_i];
                        r_old_slot <= w_i;
                    end
                end
                r_idx <= r_idx + 7'd1;
            end
            if (i_touch) begin
                r_busy <= 1'b0;
                r_age[i_touch_slot] <= i_age;
                if (i_touch_fill) begin
                    r_tag[i_touch_slot]   <= i_pos;
                    r_valid[i_touch_slot] <= 1'b1;
                end
            end
        end
    end

    `LBC_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy, "scan did not start")
    `LBC_ASSERT_IMP(a_touch_done, i_clk, i_rst_n, i_touch, o_done, "touch before scan done")
    `LBC_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, r_busy, r_idx <= i_nslots, "scan index ran away")
endmodule

// File: src/lru_block_cache_lookup_unit.sv
// ----------------------------------------------------------------------------
// lru_block_cache_lookup_unit
// Splits a read request into blocks and looks each up in an LRU tag store.
// ----------------------------------------------------------------------------
// Usage: a request (start position, byte count) enters on s_axis; one result
// per touched block leaves on m_axis, tlast on the final one. Registers are
// written on the cfg channel while idle. Per request, a restoring divider
// finds the first and last block index, then each block takes a slot scan of
// one slot per cycle over the active slots. A rejected request (over 64
// blocks or past the position space) gives one error result after the
// divides. Zero-length requests give nothing.
// The result waits in the output register while the receiver stalls; no
// further result is made until it is taken. s_axis_tready is high only
// when idle. Reset empties the tag store, zeroes the age counter and
// restores the registers to block units 1, file length 0, active slots 16.
// ----------------------------------------------------------------------------
module lru_block_cache_lookup_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // start_position[39:0], byte_count[71:40]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [111:0] m_axis_tdata,  // slot[5:0], hit[6], block_position[46:7],
                                        // copy_offset[66:47], copy_length[87:67],
                                        // fill_length[108:88], zeros[111:109]
    output logic        m_axis_tlast,   // last
    output logic        m_axis_tuser,   // error
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [39:0] i_cfg_data
);
    import lbc_pkg::*;
    `include "lru_block_cache_lookup_unit_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_DIV1, S_DIV2, S_CHECK, S_SCAN, S_OUT
    } t_state;

    t_state           r_state;
    logic [8:0]       r_bu;
    logic [39:0]      r_flen;
    logic [6:0]       r_act;
    logic [AGE_W-1:0] r_age_cnt;
    logic [39:0]      r_start;
    logic [40:0]      r_end;      // start + count
    logic [32:0]      r_remain;
    logic [40:0]      r_quo, r_rem, r_first;
    logic [5:0]       r_bit;
    logic [39:0]      r_pos;
    logic [20:0]      r_off;
    logic             r_out_v;
    logic [111:0]     r_out_d;
    logic             r_out_last, r_out_err;
    logic             r_scan_go;

    logic [20:0]      w_bs;
    logic [8:0]       w_bu;
    logic [6:0]       w_ns;
    logic [41:0]      w_trial;
    logic [40:0]      w_dividend;
    logic [40:0]      w_nblk;
    logic [32:0]      w_len;
    logic [40:0]      w_fill;
    logic             w_done;
    t_scan_res        w_res;
    logic             w_touch, w_fillsel;

    always_comb begin
        w_bu = (r_bu == 9'd0) ? 9'd1 : ((r_bu > 9'd256) ? 9'd256 : r_bu);
        w_bs = {w_bu, 12'd0};
        w_ns = (r_act == 7'd0) ? 7'd1 :
               ((r_act > 7'(NUM_SLOTS)) ? 7'(NUM_SLOTS) : r_act);
        w_dividend = (r_state == S_DIV1) ? {1'b0, r_start} : (r_end - 41'd1);
        w_trial = {r_rem, w_dividend[r_bit]} - {21'd0, w_bs};
        w_nblk  = r_quo - r_first + 41'd1;
        w_len   = {12'd0, w_bs - r_off};
        if (w_len > r_remain) w_len = r_remain;
        w_fill = (r_pos < r_flen) ? ({1'b0, r_flen} - {1'b0, r_pos}) : 41'd0;
        if (w_fill > {20'd0, w_bs}) w_fill = {20'd0, w_bs};
        w_touch   = (r_state == S_SCAN) && w_done && !r_out_v;
        w_fillsel = !w_res.hit;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_d;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_err;

    lbc_tag_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_scan_go),
        .i_pos       (r_pos),
        .i_nslots    (w_ns),
        .i_touch     (w_touch),
        .i_touch_slot(w_res.slot),
        .i_touch_fill(w_fillsel),
        .i_age       (r_age_cnt),
        .o_done      (w_done),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bu      <= 9'd1;
            r_flen    <= '0;
            r_act     <= 7'd16;
            r_age_cnt <= '0;
            r_out_v   <= 1'b0;
            r_scan_go <= 1'b0;
        end else begin
            r_scan_go <= 1'b0;
            if (r_out_v && m_axis_tready) r_out_v <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            CFG_BLOCK_UNITS:  r_bu   <= i_cfg_data[8:0];
                            CFG_FILE_LENGTH:  r_flen <= i_cfg_data;
                            CFG_ACTIVE_SLOTS: r_act  <= i_cfg_data[6:0];
                            default: ;
                        endcase
                    end
                    if (s_axis_tvalid && s_axis_tdata[71:40] != 32'd0) begin
                        r_start  <= s_axis_tdata[39:0];
                        r_end    <= {1'b0, s_axis_tdata[39:0]} + {9'd0, s_axis_tdata[71:40]};
                        r_remain <= {1'b0, s_axis_tdata[71:40]};
                        r_rem    <= '0;
                        r_bit    <= 6'd40;
                        r_state  <= S_DIV1;
                    end
                end
                S_DIV1, S_DIV2: begin
                    // restoring division, one quotient bit a cycle
                    if (!w_trial[41]) begin
                        r_rem <= w_trial[40:0];
                        r_quo <= {r_quo[39:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[39:0], w_dividend[r_bit]};
                        r_quo <= {r_quo[39:0], 1'b0};
                    end
                    if (r_bit == 6'd0) begin
                        if (r_state == S_DIV1) begin
                            r_first <= w_trial[41] ? {r_quo[39:0], 1'b0}
                                                   : {r_quo[39:0], 1'b1};
                            r_off   <= w_trial[41] ? {r_rem[19:0], w_dividend[0]}
                                                   : w_trial[20:0];
                            r_rem   <= '0;
                            r_bit   <= 6'd40;
                            r_state <= S_DIV2;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end else begin
                        r_bit <= r_bit - 6'd1;
                    end
                end
                S_CHECK: begin
                    r_pos <= r_start - {20'd0, r_off[19:0]};
                    if (w_nblk > 41'(MAX_BLOCKS) || r_end > {1'b1, 40'd0}) begin
                        if (!r_out_v) begin
                            r_out_v    <= 1'b1;
                            r_out_d    <= '0;
                            r_out_last <= 1'b1;
                            r_out_err  <= 1'b1;
                            r_state    <= S_IDLE;
                        end
                    end else begin
                        r_scan_go <= 1'b1;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_touch) begin
                        r_out_v    <= 1'b1;
                        r_out_d    <= {3'd0, (w_res.hit ? 21'd0 : w_fill[20:0]),
                                       w_len[20:0], r_off[19:0], r_pos,
                                       w_res.hit, 6'(w_res.slot)};
                        r_out_last <= (r_remain == w_len);
                        r_out_err  <= 1'b0;
                        r_age_cnt  <= r_age_cnt + 64'd1;
                        r_remain   <= r_remain - w_len;
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_remain == 33'd0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_pos     <= r_pos + {19'd0, w_bs};
                        r_off     <= '0;
                        r_scan_go <= 1'b1;
                        r_state   <= S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `LBC_ASSERT_IMP(a_no_in_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready, "ready while busy")
    `LBC_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, r_out_v && r_out_err, r_out_last && r_out_d == '0, "bad error result")
    `LBC_ASSERT_NXT(a_touch_out, i_clk, i_rst_n, w_touch, r_out_v, "result lost")
endmodule

// File: dv/lru_block_cache_lookup_unit_tb.sv
// ----------------------------------------------------------------------------
// lru_block_cache_lookup_unit_tb
// Drives read requests through the block cache lookup unit in several register
// settings. Each accepted request is split into blocks and looked up in a local
// copy of the LRU tag store; every result transaction is compared per field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_block_cache_lookup_unit_tb;
    import lbc_pkg::*;

    localparam logic [1:0]  CFG_UNUSED_IDX = 2'd3;   // no register behind it
    localparam logic [63:0] POS_SPACE      = 64'h100_0000_0000;
    localparam logic [63:0] UNIT_BYTES     = 64'd4096;
    localparam int          CYCLE_LIMIT    = 3_000_000;

    typedef struct packed {
        logic [5:0]  slot;
        logic        hit;
        logic [39:0] block_pos;
        logic [19:0] copy_off;
        logic [20:0] copy_len;
        logic [20:0] fill_len;
        logic        last;
        logic        error;
    } block_result_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata = '0;   // start_position[39:0], byte_count[71:40]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;        // slot, hit, block_position, copy_offset,
                                       // copy_length, fill_length, pad
    logic         m_axis_tlast;        // last
    logic         m_axis_tuser;        // error
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [39:0]  i_cfg_data = '0;

    lru_block_cache_lookup_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // local copy of the lookup state and registers
    logic [39:0] tag_pos   [NUM_SLOTS];
    logic        tag_valid [NUM_SLOTS];
    logic [63:0] tag_age   [NUM_SLOTS];
    logic [63:0] age_stamp = '0;
    logic [8:0]  reg_block_units = 9'd1;
    logic [39:0] reg_file_len = '0;
    logic [6:0]  reg_active = 7'd16;

    logic [71:0]   pending_requests[$];
    block_result_t expected_blocks[$];
    int            fail_count = 0;
    int            requests_taken = 0;
    int            requests_loaded = 0;
    int            cycle_count = 0;

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tag_valid[i] = 1'b0;
            tag_pos[i]   = '0;
            tag_age[i]   = '0;
        end
    end

    task automatic lookup_request(input logic [39:0] start, input logic [31:0] count);
        logic [63:0] bsize, first_blk, last_blk, pos, off, remaining, len, fill;
        int nslots, slot;
        bit hit, found;
        block_result_t r;
        if (count == 0) return;
        bsize  = (reg_block_units == 0) ? UNIT_BYTES :
                 (reg_block_units > 256) ? 256 * UNIT_BYTES : reg_block_units * UNIT_BYTES;
        nslots = (reg_active == 0) ? 1 : (reg_active > NUM_SLOTS) ? NUM_SLOTS : reg_active;
        first_blk = 64'(start) / bsize;
        last_blk  = (64'(start) + 64'(count) - 1) / bsize;
        if (last_blk - first_blk + 1 > MAX_BLOCKS || 64'(start) + 64'(count) > POS_SPACE) begin
            r = '0;
            r.last  = 1'b1;
            r.error = 1'b1;
            expected_blocks.push_back(r);
            return;
        end
        pos = first_blk * bsize;
        off = 64'(start) - pos;
        remaining = 64'(count);
        while (remaining != 0) begin
            len  = bsize - off;
            fill = 0;
            slot = 0;
            hit  = 0;
            found = 0;
            if (len > remaining) len = remaining;
            for (int i = 0; i < nslots && !hit; i++)
                if (tag_valid[i] && tag_pos[i] == pos[39:0]) begin
                    slot = i;
                    hit  = 1;
                end
            if (!hit) begin
                for (int i = 0; i < nslots && !found; i++)
                    if (!tag_valid[i]) begin
                        slot  = i;
                        found = 1;
                    end
                if (!found)
                    for (int i = 1; i < nslots; i++)
                        if (tag_age[i] < tag_age[slot]) slot = i;
                tag_pos[slot]   = pos[39:0];
                tag_valid[slot] = 1'b1;
                if (pos < 64'(reg_file_len)) begin
                    fill = 64'(reg_file_len) - pos;
                    if (fill > bsize) fill = bsize;
                end
            end
            tag_age[slot] = age_stamp;
            age_stamp     = age_stamp + 1;
            remaining     = remaining - len;
            r.slot      = 6'(slot);
            r.hit       = hit;
            r.block_pos = pos[39:0];
            r.copy_off  = off[19:0];
            r.copy_len  = len[20:0];
            r.fill_len  = fill[20:0];
            r.last      = (remaining == 0);
            r.error     = 1'b0;
            expected_blocks.push_back(r);
            pos = pos + bsize;
            off = 0;
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // input side: accept, predict; output side: compare
    always @(posedge i_clk) begin
        block_result_t e;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            lookup_request(s_axis_tdata[39:0], s_axis_tdata[71:40]);
            void'(pending_requests.pop_front());
            requests_taken++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_blocks.size() == 0) begin
                $display("%0t: unexpected result transaction, actual %h last %b error %b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                fail_count++;
            end else begin
                e = expected_blocks.pop_front();
                check_field("slot", e.slot, m_axis_tdata[5:0]);
                check_field("hit", e.hit, m_axis_tdata[6]);
                check_field("block_position", e.block_pos, m_axis_tdata[46:7]);
                check_field("copy_offset", e.copy_off, m_axis_tdata[66:47]);
                check_field("copy_length", e.copy_len, m_axis_tdata[87:67]);
                check_field("fill_length", e.fill_len, m_axis_tdata[108:88]);
                check_field("pad", 0, m_axis_tdata[111:109]);
                check_field("last", e.last, m_axis_tlast);
                check_field("error", e.error, m_axis_tuser);
            end
        end
    end

    // request driver: bursts with random gaps, holds tvalid until taken
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && requests_taken == requests_loaded)) begin
            requests_loaded = requests_taken;
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_requests[0];
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 6);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: stall mode drawn anew after a random span
    int stall_mode = 0;
    int mode_left = 0;
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 400);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [39:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BLOCK_UNITS:  reg_block_units = value[8:0];
            CFG_FILE_LENGTH:  reg_file_len    = value;
            CFG_ACTIVE_SLOTS: reg_active      = value[6:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_requests.size() > 0 || s_axis_tvalid || expected_blocks.size() > 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic logic [63:0] eff_bytes();
        return (reg_block_units == 0) ? UNIT_BYTES :
               (reg_block_units > 256) ? 256 * UNIT_BYTES : reg_block_units * UNIT_BYTES;
    endfunction

    // working-set requests around a base so that hits and evictions happen
    task automatic queue_random(input int n, input logic [39:0] base);
        logic [63:0] bs, st, cnt;
        for (int k = 0; k < n; k++) begin
            bs = eff_bytes();
            st = 64'(base) + $urandom_range(0, 24) * bs + $urandom_range(0, 32'(bs - 1));
            case ($urandom_range(0, 19))
                0: cnt = 0;
                1: cnt = $urandom;
                2: begin
                    st  = {$urandom, $urandom} & 64'hFF_FFFF_FFFF;
                    cnt = $urandom_range(1, 32'(bs * 3));
                end
                3: cnt = $urandom_range(1, 32'(bs * 64));
                default: cnt = $urandom_range(1, 32'(bs * $urandom_range(1, 5)));
            endcase
            pending_requests.push_back({cnt[31:0], st[39:0]});
        end
    endtask

    initial begin
        logic [39:0] base;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset settings: 4 KiB blocks, empty file, 16 slots
        pending_requests.push_back({32'd0, 40'd0});
        pending_requests.push_back({32'd1, 40'd0});
        pending_requests.push_back({32'd1, 40'd0});
        pending_requests.push_back({32'd2, 40'd4095});
        pending_requests.push_back({32'd262144, 40'd0});
        pending_requests.push_back({32'd262144, 40'd1});
        pending_requests.push_back({32'd1, 40'hFF_FFFF_FFFF});
        pending_requests.push_back({32'd2, 40'hFF_FFFF_FFFF});
        pending_requests.push_back({32'hFFFF_FFFF, 40'd0});
        pending_requests.push_back({32'd4096, 40'hFF_FFFF_F000});
        wait_idle();

        // block units 0 acts as 1, active slots 0 acts as 1, unknown index ignored
        write_reg(CFG_BLOCK_UNITS, 40'd0);
        write_reg(CFG_FILE_LENGTH, 40'd10000);
        write_reg(CFG_ACTIVE_SLOTS, 40'd0);
        write_reg(CFG_UNUSED_IDX, 40'hFF_FFFF_FFFF);
        pending_requests.push_back({32'd12288, 40'd0});
        pending_requests.push_back({32'd100, 40'd8192});
        pending_requests.push_back({32'd1, 40'd12288});
        pending_requests.push_back({32'd5, 40'd0});
        queue_random(20, 40'd0);
        wait_idle();

        // largest blocks, full file, slot count above the built size
        write_reg(CFG_BLOCK_UNITS, 40'd256);
        write_reg(CFG_FILE_LENGTH, 40'hFF_FFFF_FFFF);
        write_reg(CFG_ACTIVE_SLOTS, 40'd127);
        pending_requests.push_back({32'd67108864, 40'd0});
        pending_requests.push_back({32'd67108864, 40'd1});
        queue_random(25, 40'hFF_F000_0000);
        wait_idle();

        // nine-bit block units above the maximum clip to the maximum
        write_reg(CFG_BLOCK_UNITS, 40'd511);
        write_reg(CFG_ACTIVE_SLOTS, 40'd4);
        base = {8'($urandom_range(0, 255)), 32'h0};
        write_reg(CFG_FILE_LENGTH, base + 40'd7 * 40'h10_0000 + 40'd123);
        queue_random(25, base);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_BLOCK_UNITS, 40'($urandom_range(1, 6)));
            write_reg(CFG_ACTIVE_SLOTS, 40'($urandom_range(2, 16)));
            base = 40'({$urandom, $urandom}) & 40'h0F_FFFF_F000;
            write_reg(CFG_FILE_LENGTH, base + 40'($urandom_range(0, 80000)));
            queue_random(22, base);
            wait_idle();
        end

        write_reg(CFG_BLOCK_UNITS, 40'd1);
        write_reg(CFG_ACTIVE_SLOTS, 40'd16);
        queue_random(10, 40'd0);
        wait_idle();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+src
src/lbc_pkg.sv
src/lbc_tag_scan.sv
src/lru_block_cache_lookup_unit.sv
dv/lru_block_cache_lookup_unit_tb.sv
